/* hw/rtl/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the bounded substring search
// Status codes, register map and the control group handed to the cells.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam logic [1:0] ST_SEARCHING = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Register indexes; registers sit at byte address 8 * index.
	localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [1:0] REG_SEARCH_LIMIT   = 2'd2;

	localparam logic [7:0] NUL_CHAR = 8'h00;

	// Control shared by every cell of the window chain.
	typedef struct packed {
		logic load;     // a beat is accepted this cycle
		logic shift;    // the window takes in the new byte
		logic restart;  // a new haystack starts; the window empties
	} cell_ctrl_t;

endpackage

/* hw/rtl/bss_cell.sv */
// ----------------------------------------------------------------------------
// bss_cell: one byte of the search window
// Holds one haystack byte, passes it to its neighbor on a shift and compares
// the byte it will hold against its pattern character.
// ----------------------------------------------------------------------------
module bss_cell
	import bss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic [7:0] feed_byte,    // neighbor's byte, or the new text byte
	input  logic [7:0] pat_char,     // pattern character aligned to this cell
	input  logic       active,       // this cell lies within the pattern
	output logic [7:0] window_byte,  // held byte, handed to the next cell
	output logic       hit           // held-after-update byte matches
);

	logic [7:0] win_q;
	logic [7:0] win_d;

	always_comb begin
		if (ctrl.shift) begin
			win_d = feed_byte;
		end else if (ctrl.restart) begin
			win_d = NUL_CHAR;
		end else begin
			win_d = win_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= NUL_CHAR;
		end else if (ctrl.load) begin
			win_q <= win_d;
		end
	end

	assign hit         = !active || (win_d == pat_char);
	assign window_byte = win_q;

endmodule

/* hw/rtl/bounded_substring_search.sv */
// ----------------------------------------------------------------------------
// bounded_substring_search: streaming bounded substring search
// Finds the first place where a configured pattern of up to PATTERN_MAX bytes
// lies wholly within the first search_limit bytes of a byte stream.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Beat contents                       Handshake
//   s_*       in   one haystack byte, first-byte flag  s_tvalid / s_tready
//   m_*       out  status and match offset per byte    m_tvalid / m_tready
//   apb       in   pattern, length and limit registers psel / penable / pready
//
// Every input beat yields exactly one output beat. A beat is decided in the
// cycle it is accepted: the window chain shifts, every cell compares its byte
// in parallel, and the result is written into the output register at the
// accepting edge, so it is offered on m_* from the next cycle on.
// The block takes one beat per cycle while the sink keeps m_tready high; the
// output register is the only stage, so s_tready stays high as long as the output register is empty or drained.
// Reset clears the window, position, status and configuration registers to zero.
// ----------------------------------------------------------------------------
module bounded_substring_search
	import bss_pkg::*;
#(
	parameter int PATTERN_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	// Haystack stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic [0:0]  s_tuser,   // [0] first_byte

	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] status, [33:2] match_offset, rest zero

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// ------------------------------------------------------------------
	// Configuration registers. The register index is taken from
	// paddr[4:3]; an index past the list is ignored on write and reads zero.
	// ------------------------------------------------------------------
	logic [63:0] pattern_bytes_q;
	logic [3:0]  pattern_length_q;
	logic [31:0] search_limit_q;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= '0;
			pattern_length_q <= '0;
			search_limit_q   <= '0;
		end else if (cfg_write) begin
			case (paddr[4:3])
				REG_PATTERN_BYTES:  pattern_bytes_q  <= pwdata;
				REG_PATTERN_LENGTH: pattern_length_q <= pwdata[3:0];
				REG_SEARCH_LIMIT:   search_limit_q   <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_PATTERN_BYTES:  prdata = pattern_bytes_q;
			REG_PATTERN_LENGTH: prdata = {60'd0, pattern_length_q};
			REG_SEARCH_LIMIT:   prdata = {32'd0, search_limit_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Effective pattern length: the register value clamped to PATTERN_MAX,
	// cut short at the first NUL character of the pattern.
	// ------------------------------------------------------------------
	logic [3:0] clamp_len;
	logic [3:0] eff_len;

	always_comb begin
		clamp_len = (pattern_length_q > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX)
		                                                 : pattern_length_q;
		eff_len = clamp_len;
		for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
			if ((4'(k) < clamp_len) && (pattern_bytes_q[8*k +: 8] == NUL_CHAR)) begin
				eff_len = 4'(k);
			end
		end
	end

	// ------------------------------------------------------------------
	// Search state. A first-byte beat restarts the search before the byte
	// itself is looked at, so the "current" values below already fold in
	// the restart.
	// ------------------------------------------------------------------
	logic [1:0]  status_q;
	logic [31:0] pos_q;
	logic [31:0] offset_q;

	logic        accept;
	logic        restart;
	logic [7:0]  text_byte;
	logic [1:0]  status_cur;
	logic [31:0] pos_cur;
	logic [31:0] offset_cur;
	logic        searching;
	logic [32:0] pos_next;
	logic        window_match;
	logic [1:0]  status_d;
	logic [31:0] offset_d;
	logic [31:0] pos_d;
	cell_ctrl_t  ctrl;

	assign accept     = s_tvalid && s_tready;
	assign restart    = s_tuser[0];
	assign text_byte  = s_tdata;
	assign status_cur = restart ? ST_SEARCHING : status_q;
	assign pos_cur    = restart ? 32'd0 : pos_q;
	assign offset_cur = restart ? 32'd0 : offset_q;
	assign searching  = (status_cur == ST_SEARCHING);
	assign pos_next   = {1'b0, pos_cur} + 33'd1;

	// The window only moves for a real text byte of an undecided search.
	assign ctrl.load    = accept;
	assign ctrl.restart = restart;
	assign ctrl.shift   = searching && (eff_len != 4'd0) && (text_byte != NUL_CHAR);

	// ------------------------------------------------------------------
	// Window chain. Cell 0 holds the newest byte; cell j is compared with
	// pattern character eff_len-1-j, so the oldest byte in use meets the
	// first pattern character. On a restart the neighbors read as empty.
	// ------------------------------------------------------------------
	logic [7:0] win_bytes [PATTERN_MAX];
	logic [7:0] feed      [PATTERN_MAX];
	logic [7:0] pat_sel   [PATTERN_MAX];
	logic       active    [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hits;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		logic [3:0] pat_idx;

		if (j == 0) begin : g_head
			assign feed[j] = text_byte;
		end else begin : g_body
			assign feed[j] = restart ? NUL_CHAR : win_bytes[j-1];
		end

		assign active[j]  = (4'(j) < eff_len);
		assign pat_idx    = eff_len - 4'(j) - 4'd1;
		assign pat_sel[j] = pattern_bytes_q[8*pat_idx[2:0] +: 8];

		bss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.feed_byte   (feed[j]),
			.pat_char    (pat_sel[j]),
			.active      (active[j]),
			.window_byte (win_bytes[j]),
			.hit         (hits[j])
		);
	end

	assign window_match = &hits;

	// ------------------------------------------------------------------
	// Decision for the accepted byte. A match counts only once enough bytes
	// have arrived and its last byte lies within the limit; once the next
	// position reaches the limit no later match can fit.
	// ------------------------------------------------------------------
	always_comb begin
		status_d = status_cur;
		offset_d = offset_cur;
		pos_d    = pos_cur;
		if (searching) begin
			if (eff_len == 4'd0) begin
				status_d = ST_FOUND;
				offset_d = 32'd0;
			end else if (text_byte == NUL_CHAR) begin
				status_d = ST_NOT_FOUND;
			end else begin
				if ((pos_next >= {29'd0, eff_len}) &&
				    (pos_next <= {1'b0, search_limit_q}) && window_match) begin
					status_d = ST_FOUND;
					offset_d = 32'(pos_next - {29'd0, eff_len});
				end else if (pos_next >= {1'b0, search_limit_q}) begin
					status_d = ST_NOT_FOUND;
				end
				// The position saturates at its all-ones value.
				if (pos_cur != '1) begin
					pos_d = pos_next[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_SEARCHING;
			pos_q    <= '0;
			offset_q <= '0;
		end else if (accept) begin
			status_q <= status_d;
			pos_q    <= pos_d;
			offset_q <= offset_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register. A new beat may enter in the same cycle the held
	// result is taken, so the stream runs at one beat per cycle while m_tready stays high.
	// ------------------------------------------------------------------
	logic        m_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_offset_q;

	assign s_tready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_d;
			out_offset_q <= (status_d == ST_FOUND) ? offset_d : 32'd0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_offset_q, out_status_q};

endmodule

/* dv/tb_bounded_substring_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_substring_search: self-checking bench for the substring search
// Streams haystacks through the block under random valid and ready gaps and
// checks every result beat against a cycle-free model of the search state.
// The pattern, length and limit registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_bounded_substring_search;
	import bss_pkg::*;

	localparam int          PATTERN_MAX = 8;
	localparam int          STALL_LIMIT = 4000;
	localparam logic [4:0]  ADDR_PATTERN = {REG_PATTERN_BYTES, 3'b000};
	localparam logic [4:0]  ADDR_LENGTH  = {REG_PATTERN_LENGTH, 3'b000};
	localparam logic [4:0]  ADDR_LIMIT   = {REG_SEARCH_LIMIT, 3'b000};
	// Index three has no register behind it; a write there must change nothing.
	localparam logic [4:0]  ADDR_UNUSED  = 5'd24;
	localparam logic [31:0] POSITION_MAX = 32'hFFFF_FFFF;

	typedef struct {
		logic [7:0] text;
		logic       first;
	} hay_beat_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] offset;
	} search_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	bounded_substring_search #(.PATTERN_MAX(PATTERN_MAX)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Haystack beats waiting for the driver, and results the block still owes.
	hay_beat_t      hay_q[$];
	search_result_t result_q[$];
	int             beats_pending = 0;  // queued or on the bus, not yet accepted
	int             beats_total = 0;
	int             error_count = 0;
	int             stall_cycles = 0;
	logic           hay_taken = 1'b0;
	logic           hay_calm = 1'b0;    // phases with no source gaps
	logic           res_calm = 1'b0;    // phases with no sink stalls
	int             hay_gap = 0;
	int             res_stall = 0;

	// Register copies, updated on the same edge at which the block takes them.
	logic [63:0] cfg_pattern = '0;
	logic [3:0]  cfg_length = '0;
	logic [31:0] cfg_limit = '0;

	// Search state: newest byte in entry 0 of the window.
	logic [7:0]  win [PATTERN_MAX];
	logic [31:0] cur_pos = '0;
	logic [1:0]  cur_status = ST_SEARCHING;
	logic [31:0] cur_offset = '0;

	initial begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			win[k] = NUL_CHAR;
		end
	end

	// Mostly back to back, sometimes a short gap, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	// Length the search really uses: clamped to the window and cut at the
	// first zero character of the pattern.
	function automatic int unsigned pattern_span(logic [63:0] pat, logic [3:0] len);
		int unsigned lim;
		lim = (len > PATTERN_MAX) ? PATTERN_MAX : len;
		for (int unsigned k = 0; k < lim; k++) begin
			if (pat[8*k +: 8] == NUL_CHAR) return k;
		end
		return lim;
	endfunction

	// Advances the search by one accepted byte and records the result beat
	// the block has to send for it.
	task automatic advance_search(input logic [7:0] text, input logic first);
		int unsigned    span;
		logic [32:0]    next_pos;
		logic           hit;
		search_result_t res;
		if (first) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win[k] = NUL_CHAR;
			end
			cur_pos = '0;
			cur_status = ST_SEARCHING;
			cur_offset = '0;
		end
		if (cur_status == ST_SEARCHING) begin
			span = pattern_span(cfg_pattern, cfg_length);
			next_pos = {1'b0, cur_pos} + 33'd1;
			if (span == 0) begin
				// An empty pattern matches at once, NUL byte or not.
				cur_status = ST_FOUND;
				cur_offset = '0;
			end else if (text == NUL_CHAR) begin
				cur_status = ST_NOT_FOUND;
			end else begin
				for (int k = PATTERN_MAX - 1; k > 0; k--) begin
					win[k] = win[k-1];
				end
				win[0] = text;
				hit = 1'b1;
				for (int unsigned k = 0; k < span; k++) begin
					if (win[span-1-k] != cfg_pattern[8*k +: 8]) hit = 1'b0;
				end
				if (next_pos >= span && next_pos <= {1'b0, cfg_limit} && hit) begin
					cur_status = ST_FOUND;
					cur_offset = 32'(next_pos - span);
				end else if (next_pos >= {1'b0, cfg_limit}) begin
					// No later match could still end inside the limit.
					cur_status = ST_NOT_FOUND;
				end
				if (cur_pos != POSITION_MAX) cur_pos = cur_pos + 32'd1;
			end
		end
		res.status = cur_status;
		res.offset = (cur_status == ST_FOUND) ? cur_offset : 32'd0;
		result_q.push_back(res);
	endtask

	// Source side: a beat stays on the bus until taken, then the next one
	// follows after a random gap.
	always @(negedge clk) begin
		hay_beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !hay_taken) begin
			// Hold the current beat.
		end else if (hay_gap != 0) begin
			s_tvalid <= 1'b0;
			hay_gap <= hay_gap - 1;
		end else if (hay_q.size() != 0) begin
			b = hay_q.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= b.text;
			s_tuser <= b.first;
			hay_gap <= hay_calm ? 0 : pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Sink side: ready drops for random stretches.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (res_stall != 0) begin
			m_tready <= 1'b0;
			res_stall <= res_stall - 1;
		end else begin
			m_tready <= 1'b1;
			res_stall <= res_calm ? 0 : pick_gap();
		end
	end

	// Everything is sampled on the rising edge, before the block updates.
	always @(posedge clk) begin
		search_result_t want;
		logic           active;
		if (arst_n) begin
			active = 1'b0;
			hay_taken = s_tvalid && s_tready;
			if (hay_taken) begin
				advance_search(s_tdata, s_tuser[0]);
				beats_pending--;
				active = 1'b1;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_PATTERN: cfg_pattern = pwdata;
					ADDR_LENGTH:  cfg_length = pwdata[3:0];
					ADDR_LIMIT:   cfg_limit = pwdata[31:0];
					default: ;
				endcase
				active = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				active = 1'b1;
				if (result_q.size() == 0) begin
					$display("%0t: result beat with none expected, got status %0d offset %0d",
						$realtime, m_tdata[1:0], m_tdata[33:2]);
					error_count++;
				end else begin
					want = result_q.pop_front();
					if (m_tdata[1:0] !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$realtime, want.status, m_tdata[1:0]);
						error_count++;
					end
					if (m_tdata[33:2] !== want.offset) begin
						$display("%0t: match_offset expected %0d, actual %0d",
							$realtime, want.offset, m_tdata[33:2]);
						error_count++;
					end
					if (m_tdata[39:34] !== 6'd0) begin
						$display("%0t: tdata padding expected 0, actual %h",
							$realtime, m_tdata[39:34]);
						error_count++;
					end
				end
			end
			stall_cycles = active ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic add_beat(input logic [7:0] text, input logic first);
		hay_beat_t b;
		b.text = text;
		b.first = first;
		hay_q.push_back(b);
		beats_pending++;
		beats_total++;
	endtask

	// Returns once every queued beat is accepted and every result has come.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (beats_pending != 0 || result_q.size() != 0);
	endtask

	// Setup cycle, then access cycle; the write lands on the edge that ends the access cycle.
	task automatic apb_write(input logic [4:0] addr, input logic [63:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_search(input logic [63:0] pat, input logic [3:0] len,
			input logic [31:0] lim);
		apb_write(ADDR_PATTERN, pat);
		apb_write(ADDR_LENGTH, {60'd0, len});
		apb_write(ADDR_LIMIT, {32'd0, lim});
	endtask

	initial begin : stimulus
		logic [63:0] pat;
		logic [3:0]  plen;
		logic [31:0] lim;
		logic [7:0]  text [64];
		int          hay_count;
		int          hay_len;
		int          at;
		int          r;
		int unsigned span;
		logic        cut_first;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With the reset registers the pattern is empty; bytes before any
		// first-byte flag still form a haystack from index 0.
		add_beat(8'h41, 1'b0);
		add_beat(NUL_CHAR, 1'b0);
		wait_drained();

		// Pattern "ab" inside a limit of four bytes.
		set_search(64'h6261, 4'd2, 32'd4);
		apb_write(ADDR_UNUSED, {$urandom, $urandom});
		add_beat("x", 1'b1); add_beat("a", 1'b0); add_beat("b", 1'b0);
		// Match ending exactly on the last byte of the limit.
		add_beat("x", 1'b1); add_beat("y", 1'b0); add_beat("a", 1'b0); add_beat("b", 1'b0);
		// Match that would end past the limit; the trailing byte is ignored.
		add_beat("x", 1'b1); add_beat("y", 1'b0); add_beat("z", 1'b0);
		add_beat("a", 1'b0); add_beat("b", 1'b0);
		// A NUL byte ends the haystack.
		add_beat(NUL_CHAR, 1'b1);
		wait_drained();

		// Length above the window clamps to eight; all-ones bytes and limit.
		set_search(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
		add_beat(8'hFF, 1'b1);
		repeat (7) add_beat(8'hFF, 1'b0);
		wait_drained();

		// A zero limit with a real pattern gives up on the first byte.
		set_search(64'h6261, 4'd2, 32'd0);
		add_beat("a", 1'b1);
		wait_drained();

		while (beats_total < 1025) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				// Small alphabet so that random text often matches.
				for (int k = 0; k < 8; k++) pat[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 3));
			end else if (r < 8) begin
				pat = {$urandom, $urandom};
			end else begin
				for (int k = 0; k < 8; k++) pat[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 3));
				pat[8*$urandom_range(0, 7) +: 8] = NUL_CHAR;
			end
			r = $urandom_range(0, 19);
			plen = (r == 0) ? 4'd0 : (r < 3) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(1, 8));
			r = $urandom_range(0, 9);
			lim = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom
				: 32'($urandom_range(1, 24));
			hay_calm = ($urandom_range(0, 4) == 0);
			res_calm = ($urandom_range(0, 4) == 0);
			set_search(pat, plen, lim);
			span = pattern_span(pat, plen);

			hay_count = $urandom_range(3, 8);
			for (int h = 0; h < hay_count; h++) begin
				hay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
					: $urandom_range(1, 16);
				for (int i = 0; i < hay_len; i++) begin
					r = $urandom_range(0, 9);
					if (r < 6) text[i] = pat[8*$urandom_range(0, 7) +: 8];
					else if (r < 9) text[i] = 8'(8'h61 + $urandom_range(0, 3));
					else text[i] = 8'($urandom_range(0, 255));
				end
				if ($urandom_range(0, 1) == 1) begin
					at = $urandom_range(0, hay_len - 1);
					for (int unsigned k = 0; k < span; k++) begin
						if (at + k < hay_len) text[at + k] = pat[8*k +: 8];
					end
				end
				if ($urandom_range(0, 6) == 0) text[$urandom_range(0, hay_len - 1)] = NUL_CHAR;
				// Now and then a haystack runs on from the previous one.
				cut_first = ($urandom_range(0, 19) == 0);
				for (int i = 0; i < hay_len; i++) begin
					add_beat(text[i], (i == 0) ? !cut_first : ($urandom_range(0, 39) == 0));
				end
			end
			wait_drained();
		end

		hay_calm = 1'b1;
		res_calm = 1'b1;
		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0 && result_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
